// File: rtl/psd_pkg.sv
package psd_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned DiffW  = CoordW + 1;       // coordinate differences
  localparam int unsigned ProdW  = 2 * DiffW;        // one 17x17 product
  localparam int unsigned DotW   = ProdW + 1;        // sum of two products
  localparam int unsigned SqW    = ProdW;            // squared distance, unsigned
  localparam int unsigned NumW   = 2 * SqW;          // cross product squared
  localparam int unsigned DistW  = SqW / 2;          // floor square root
  localparam int unsigned HalfW  = SqW / 2;          // split for partial products
  localparam int unsigned RemW   = DistW + 1;        // square root remainder
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [1:0] {
    RegionStart    = 2'd0,
    RegionEnd      = 2'd1,
    RegionInterior = 2'd2
  } region_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgStartX = 2'd0,
    CfgStartY = 2'd1,
    CfgEndX   = 2'd2,
    CfgEndY   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
  } in_req_t;

  typedef struct packed {
    logic [DistW-1:0] distance;
    logic [1:0]       nearest_region;
  } out_req_t;

endpackage

// File: rtl/point_segment_distance.sv
// point-to-segment distance: each request carries a query point (signed q11.4)
// and yields the floor square root of its squared distance to the segment held
// in the four config registers, plus the nearest region (start, end, interior).
// one request is taken per cycle while the output is not stalled. a request
// passes 58 register stages, the first one loaded by the accepting edge: five
// for differences, products, region choice, partial products and divider
// entry, the restoring divider (one quotient bit per stage, 34 stages), the
// square root entry, the bitwise square root (one root bit per stage, 17
// stages) and the output register.
// config writes are always ready and must only happen while the pipeline is
// empty. a stalled output freezes the whole pipeline, nothing is dropped.
module point_segment_distance import psd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CoordW-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_req_t              in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_req_t             out_req_o
);

  localparam int unsigned DivStages  = SqW;
  localparam int unsigned SqrtStages = DistW;

  // config registers
  logic signed [CoordW-1:0] sx_q, sy_q, ex_q, ey_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q <= '0;
      sy_q <= '0;
      ex_q <= '0;
      ey_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgStartX: sx_q <= cfg_data_i;
        CfgStartY: sy_q <= cfg_data_i;
        CfgEndX:   ex_q <= cfg_data_i;
        CfgEndY:   ey_q <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  // segment vector and its squared length, refreshed every cycle
  logic signed [DiffW-1:0] vx_q, vy_q;
  logic [SqW-1:0]          c2_q;
  logic signed [ProdW-1:0] vxx, vyy;

  assign vxx = vx_q * vx_q;
  assign vyy = vy_q * vy_q;

  always_ff @(posedge clk_i) begin
    vx_q <= DiffW'(ex_q) - DiffW'(sx_q);
    vy_q <= DiffW'(ey_q) - DiffW'(sy_q);
    c2_q <= SqW'(vxx) + SqW'(vyy);
  end

  // global advance: everything moves unless the output holds a stalled result
  logic en;
  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  // stage 1: differences
  logic                    v1_q;
  logic signed [DiffW-1:0] wx_q, wy_q, ux_q, uy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      wx_q <= DiffW'(in_req_i.point_x) - DiffW'(sx_q);
      wy_q <= DiffW'(in_req_i.point_y) - DiffW'(sy_q);
      ux_q <= DiffW'(in_req_i.point_x) - DiffW'(ex_q);
      uy_q <= DiffW'(in_req_i.point_y) - DiffW'(ey_q);
    end
  end

  // stage 2: products
  logic                    v2_q;
  logic signed [ProdW-1:0] p_wvx_q, p_wvy_q, p_wxvy_q, p_wyvx_q;
  logic signed [ProdW-1:0] p_wxx_q, p_wyy_q, p_uxx_q, p_uyy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_wvx_q  <= wx_q * vx_q;
      p_wvy_q  <= wy_q * vy_q;
      p_wxvy_q <= wx_q * vy_q;
      p_wyvx_q <= wy_q * vx_q;
      p_wxx_q  <= wx_q * wx_q;
      p_wyy_q  <= wy_q * wy_q;
      p_uxx_q  <= ux_q * ux_q;
      p_uyy_q  <= uy_q * uy_q;
    end
  end

  // stage 3: dot, cross, region choice
  logic                   v3_q;
  region_e                reg3_q;
  logic [SqW-1:0]         d2_3_q;
  logic [SqW-1:0]         acr_q;
  logic signed [DotW-1:0] c1, cr;
  logic [SqW-1:0]         ds, de;
  region_e                reg3_d;

  always_comb begin
    c1 = DotW'(p_wvx_q) + DotW'(p_wvy_q);
    cr = DotW'(p_wxvy_q) - DotW'(p_wyvx_q);
    ds = SqW'(p_wxx_q) + SqW'(p_wyy_q);
    de = SqW'(p_uxx_q) + SqW'(p_uyy_q);
    if (c1 <= 0) begin
      reg3_d = RegionStart;
    end else if ({1'b0, c2_q} <= $unsigned(c1)) begin
      reg3_d = RegionEnd;
    end else begin
      reg3_d = RegionInterior;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en) v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      reg3_q <= reg3_d;
      d2_3_q <= (reg3_d == RegionEnd) ? de : ds;
      acr_q  <= cr[DotW-1] ? SqW'(-cr) : SqW'(cr);
    end
  end

  // stage 4: partial products of the cross product square
  logic              v4_q;
  region_e           reg4_q;
  logic [SqW-1:0]    d2_4_q;
  logic [SqW-1:0]    pp_ll_q, pp_lh_q, pp_hh_q;
  logic [HalfW-1:0]  ah, al;

  assign ah = acr_q[SqW-1:HalfW];
  assign al = acr_q[HalfW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (en) v4_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      reg4_q  <= reg3_q;
      d2_4_q  <= d2_3_q;
      pp_ll_q <= al * al;
      pp_lh_q <= ah * al;
      pp_hh_q <= ah * ah;
    end
  end

  // stage 5: divider entry; outside the interior divide by one
  typedef struct packed {
    logic [SqW-1:0] r;
    logic [SqW-1:0] lo;
    logic [SqW-1:0] d;
    region_e        region;
  } div_t;

  typedef struct packed {
    logic [SqW-1:0]   x;
    logic [RemW-1:0]  rem;
    logic [DistW-1:0] root;
    region_e          region;
  } sqrt_t;

  logic [NumW-1:0] sq, num;
  div_t            div_d;

  always_comb begin
    sq  = {pp_hh_q, {SqW{1'b0}}} + (NumW'(pp_lh_q) << (HalfW + 1)) + NumW'(pp_ll_q);
    num = (reg4_q == RegionInterior) ? sq : NumW'(d2_4_q);
    div_d.r      = num[NumW-1:SqW];
    div_d.lo     = num[SqW-1:0];
    div_d.d      = (reg4_q == RegionInterior) ? c2_q : SqW'(1);
    div_d.region = reg4_q;
  end

  logic  dv_q [DivStages+1];
  div_t  ds_q [DivStages+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_q[0] <= 1'b0;
    else if (en) dv_q[0] <= v4_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) ds_q[0] <= div_d;
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 1; k <= DivStages; k++) begin : g_div
    logic [SqW:0] r2, rs;
    logic         qb;
    div_t         nx;

    always_comb begin
      r2 = {ds_q[k-1].r, ds_q[k-1].lo[SqW-1]};
      rs = r2 - {1'b0, ds_q[k-1].d};
      qb = (r2 >= {1'b0, ds_q[k-1].d});
      nx.r      = qb ? rs[SqW-1:0] : r2[SqW-1:0];
      nx.lo     = {ds_q[k-1].lo[SqW-2:0], qb};
      nx.d      = ds_q[k-1].d;
      nx.region = ds_q[k-1].region;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_q[k] <= 1'b0;
      else if (en) dv_q[k] <= dv_q[k-1];
    end

    always_ff @(posedge clk_i) begin
      if (en) ds_q[k] <= nx;
    end
  end

  // bitwise square root, one root bit per stage
  logic  sv_q [SqrtStages+1];
  sqrt_t ss_q [SqrtStages+1];
  sqrt_t s0;

  always_comb begin
    s0.x      = ds_q[DivStages].lo;
    s0.rem    = '0;
    s0.root   = '0;
    s0.region = ds_q[DivStages].region;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sv_q[0] <= 1'b0;
    else if (en) sv_q[0] <= dv_q[DivStages];
  end

  always_ff @(posedge clk_i) begin
    if (en) ss_q[0] <= s0;
  end

  for (genvar k = 1; k <= SqrtStages; k++) begin : g_sqrt
    logic [RemW+1:0] rem2, trial, diff;
    logic            take;
    sqrt_t           nx;

    always_comb begin
      rem2  = {ss_q[k-1].rem, ss_q[k-1].x[SqW-1:SqW-2]};
      trial = {1'b0, ss_q[k-1].root, 2'b01};
      diff  = rem2 - trial;
      take  = (rem2 >= trial);
      nx.x      = {ss_q[k-1].x[SqW-3:0], 2'b00};
      nx.rem    = take ? diff[RemW-1:0] : rem2[RemW-1:0];
      nx.root   = {ss_q[k-1].root[DistW-2:0], take};
      nx.region = ss_q[k-1].region;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sv_q[k] <= 1'b0;
      else if (en) sv_q[k] <= sv_q[k-1];
    end

    always_ff @(posedge clk_i) begin
      if (en) ss_q[k] <= nx;
    end
  end

  // output register
  logic     out_valid_q;
  out_req_t out_req_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= sv_q[SqrtStages];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_req_q.distance       <= ss_q[SqrtStages].root;
      out_req_q.nearest_region <= ss_q[SqrtStages].region;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

endmodule

// File: tb/tb_point_segment_distance.sv
module tb_point_segment_distance;
  timeunit 1ns;
  timeprecision 1ps;

  import psd_pkg::*;

  localparam int unsigned PipeDepth  = 57;    // request to result through the pipeline
  localparam int unsigned IdleLimit  = 5000;  // cycles with no transfer before giving up
  localparam int unsigned LongHold   = 300;   // receiver hold-off, well above pipe depth
  localparam int unsigned MaxReports = 10;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CoordW-1:0]   cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  in_req_t             in_req_i;
  logic                out_valid_o;
  logic                out_stall_i;
  out_req_t            out_req_o;

  point_segment_distance dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // segment as the block should currently hold it
  logic signed [CoordW-1:0] seg_sx, seg_sy, seg_ex, seg_ey;

  in_req_t  point_q[$];     // query points waiting to be sent
  out_req_t dist_q[$];      // distances owed by the block, oldest first

  int unsigned mismatches;
  bit          quiet;       // no idling on either side
  bit          hold_req;    // ask the receiver for one long hold-off
  bit          hold_done;   // the long hold-off has been started
  int unsigned idle_cycles;

  // floor square root, one result bit per step
  function automatic logic [63:0] floor_sqrt(logic [63:0] n);
    logic [63:0] root;
    logic [63:0] bitpos;
    root   = '0;
    bitpos = 64'd1 << 62;
    while (bitpos > n) bitpos >>= 2;
    while (bitpos != 0) begin
      if (n >= root + bitpos) begin
        n    = n - (root + bitpos);
        root = (root >> 1) + bitpos;
      end else begin
        root >>= 1;
      end
      bitpos >>= 2;
    end
    return root;
  endfunction

  // distance from a query point to the held segment
  function automatic out_req_t distance_to_segment(in_req_t pt);
    longint      px, py, vx, vy, wx, wy, dot_wv, len_sq, cross_wv;
    logic [127:0] cross_abs, cross_sq;
    logic [63:0] dsq;
    out_req_t    res;
    px     = longint'(pt.point_x);
    py     = longint'(pt.point_y);
    vx     = longint'(seg_ex) - longint'(seg_sx);
    vy     = longint'(seg_ey) - longint'(seg_sy);
    wx     = px - longint'(seg_sx);
    wy     = py - longint'(seg_sy);
    dot_wv = wx * vx + wy * vy;
    len_sq = vx * vx + vy * vy;
    if (dot_wv <= 0) begin
      // start side, also every point of a degenerate segment
      dsq = 64'(wx * wx + wy * wy);
      res.nearest_region = RegionStart;
    end else if (len_sq <= dot_wv) begin
      dsq = 64'((px - seg_ex) * (px - seg_ex) + (py - seg_ey) * (py - seg_ey));
      res.nearest_region = RegionEnd;
    end else begin
      cross_wv  = wx * vy - wy * vx;
      cross_abs = (cross_wv < 0) ? 128'(-cross_wv) : 128'(cross_wv);
      cross_sq  = cross_abs * cross_abs;
      dsq       = 64'(cross_sq / 128'(len_sq));
      res.nearest_region = RegionInterior;
    end
    res.distance = DistW'(floor_sqrt(dsq));
    return res;
  endfunction

  // sender: holds a point until it is taken, random gaps between points
  int unsigned send_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_req_i   <= '0;
      send_gap   <= 0;
    end else begin
      automatic bit busy = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        dist_q.push_back(distance_to_segment(in_req_i));
        void'(point_q.pop_front());
        busy = 1'b0;
      end
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap   <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
          send_gap   <= $urandom_range(1, 12) - 1;
          in_valid_i <= 1'b0;
        end else if (point_q.size() > 0) begin
          in_valid_i <= 1'b1;
          in_req_i   <= point_q[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result against the oldest owed distance
  int unsigned stall_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
      hold_done   <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (dist_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("unexpected result: distance %0d region %0d",
                     out_req_o.distance, out_req_o.nearest_region);
        end else begin
          automatic out_req_t want = dist_q.pop_front();
          if (out_req_o.distance !== want.distance ||
              out_req_o.nearest_region !== want.nearest_region) begin
            mismatches++;
            if (mismatches <= MaxReports)
              $display("mismatch: distance exp %0d got %0d, region exp %0d got %0d",
                       want.distance, out_req_o.distance,
                       want.nearest_region, out_req_o.nearest_region);
          end
        end
      end
      if (hold_req && !hold_done) begin
        hold_done   <= 1'b1;
        stall_left  <= LongHold;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left  <= stall_left - 1;
        out_stall_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall_left  <= $urandom_range(1, 12) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic signed [CoordW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CfgStartX: seg_sx = val;
      CfgStartY: seg_sy = val;
      CfgEndX:   seg_ex = val;
      default:   seg_ey = val;
    endcase
  endtask

  task automatic set_segment(int sx, int sy, int ex, int ey);
    write_reg(CfgStartX, CoordW'(sx));
    write_reg(CfgStartY, CoordW'(sy));
    write_reg(CfgEndX, CoordW'(ex));
    write_reg(CfgEndY, CoordW'(ey));
  endtask

  task automatic queue_point(int x, int y);
    in_req_t pt;
    pt.point_x = CoordW'(x);
    pt.point_y = CoordW'(y);
    point_q.push_back(pt);
  endtask

  // let everything queued drain, then let the pipeline settle
  task automatic drain();
    while (point_q.size() > 0 || dist_q.size() > 0) @(posedge clk_i);
    repeat (PipeDepth + 5) @(posedge clk_i);
  endtask

  function automatic int clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  // mostly points around the segment, some anywhere in range
  task automatic queue_random_point();
    longint t, ox, oy, lim;
    if ($urandom_range(0, 3) == 0) begin
      queue_point(int'($urandom_range(0, 65535)) - 32768,
                  int'($urandom_range(0, 65535)) - 32768);
    end else begin
      t   = longint'($urandom_range(0, 1400)) - 200;
      lim = 64 << $urandom_range(0, 8);
      ox  = longint'($urandom_range(0, 2 * lim)) - lim;
      oy  = longint'($urandom_range(0, 2 * lim)) - lim;
      queue_point(clamp16(seg_sx + ((seg_ex - seg_sx) * t) / 1000 + ox),
                  clamp16(seg_sy + ((seg_ey - seg_sy) * t) / 1000 + oy));
    end
  endtask

  task automatic random_segment();
    int span;
    if ($urandom_range(0, 4) == 0) begin
      set_segment(int'($urandom_range(0, 65535)) - 32768,
                  int'($urandom_range(0, 65535)) - 32768,
                  int'($urandom_range(0, 65535)) - 32768,
                  int'($urandom_range(0, 65535)) - 32768);
    end else begin
      span = 16 << $urandom_range(0, 10);
      set_segment(int'($urandom_range(0, 2 * span)) - span,
                  int'($urandom_range(0, 2 * span)) - span,
                  int'($urandom_range(0, 2 * span)) - span,
                  int'($urandom_range(0, 2 * span)) - span);
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgStartX;
    cfg_data_i  = '0;
    quiet       = 1'b0;
    hold_req    = 1'b0;
    seg_sx = '0;
    seg_sy = '0;
    seg_ex = '0;
    seg_ey = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset segment is a single point at the origin
    queue_point(0, 0);
    queue_point(-32768, -32768);
    queue_point(32767, 32767);
    queue_point(32767, -32768);
    drain();

    // ordinary segment: each region, endpoints, perpendicular foot
    set_segment(-1600, -800, 2400, 1200);
    queue_point(-1600, -800);
    queue_point(2400, 1200);
    queue_point(-3000, -900);
    queue_point(5000, 1300);
    queue_point(400, 200);
    queue_point(0, 1000);
    queue_point(1000, -3000);
    queue_point(-32768, 32767);
    queue_point(32767, -32768);
    drain();

    // longest segment and far corners give the largest products
    set_segment(-32768, -32768, 32767, 32767);
    queue_point(-32768, 32767);
    queue_point(32767, -32768);
    queue_point(0, 0);
    queue_point(-32768, -32768);
    queue_point(32767, 32767);
    drain();

    // degenerate segment away from the origin
    set_segment(32767, -32768, 32767, -32768);
    queue_point(-32768, 32767);
    queue_point(32767, -32768);
    queue_point(100, 100);
    drain();

    // random segments and points; the held phase queues more than the pipe holds
    for (int ph = 0; ph < 6; ph++) begin
      random_segment();
      for (int k = 0; k < ((ph == 2) ? 100 : 40); k++) queue_random_point();
      if (ph == 2) begin
        // receiver holds off while the sender keeps the pipe full
        @(posedge clk_i);
        hold_req <= 1'b1;
      end
      drain();
    end

    // last part without any idling
    quiet = 1'b1;
    random_segment();
    for (int k = 0; k < 80; k++) queue_random_point();
    drain();

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/psd_pkg.sv
rtl/point_segment_distance.sv
tb/tb_point_segment_distance.sv
